// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the bounded sequence list.
// No dependencies; each RTL file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Always-true property, sampled on clk, off during reset.
`define BSL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent holds, consequent must hold on the following edge.
`define BSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bsl_pkg.sv
// Types and constants for the bounded sequence list.
// No dependencies; used by every module of the block.
`default_nettype none

package bsl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 5;
	localparam int CNT_W     = 5;

	typedef enum logic [1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_BACK  = 2'd1,
		OP_DELETE    = 2'd2,
		OP_READ_ALL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		op_t                      operation;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} in_item_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] entry_value;
		logic [CNT_W-1:0]         entry_count;
		logic                     last;
	} out_item_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	typedef struct packed {
		logic exec;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic cnt_zero;
		logic rd_last;
	} dp_status_t;

endpackage

`default_nettype wire

// File: hdl/bounded_sequence_list_top.sv
// Top level of the bounded sequence list: controller plus datapath.
// Depends on bsl_pkg, bsl_ctrl and bsl_dpath.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------
//   request | cmd_valid/cmd_ready | cmd (bsl_pkg::in_item_t)
//   result  | rsp_valid/rsp_ready | rsp (bsl_pkg::out_item_t)
//
// Insert and delete act in the accept cycle: a front insert shifts every cell, a back
// insert writes one cell, a delete shifts the cells from its position on. A read-out
// rotates the bank one cell per cycle, unless stalled, into the single result register.
// arst_n clears the count, the FSM and the result valid; cell contents are not reset.
// A stalled result register holds off both new requests and read-out steps.
`default_nettype none

module bounded_sequence_list_top #(
	parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  bsl_pkg::in_item_t  cmd,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output bsl_pkg::out_item_t rsp
);

	bsl_pkg::ctrl_cmd_t  ctrl_cmd;
	bsl_pkg::dp_status_t dp_status;

	bsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.operation (cmd.operation),
		.dp_status (dp_status),
		.cmd_ready (cmd_ready),
		.ctrl_cmd  (ctrl_cmd)
	);

	bsl_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_cmd  (ctrl_cmd),
		.cmd       (cmd),
		.dp_status (dp_status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// File: hdl/bsl_ctrl.sv
// Controller FSM: accepts operations and sequences a read-out.
// Depends on bsl_pkg.
`default_nettype none

module bsl_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	input  bsl_pkg::op_t        operation,
	input  bsl_pkg::dp_status_t dp_status,
	output logic                cmd_ready,
	output bsl_pkg::ctrl_cmd_t  ctrl_cmd
);

	bsl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsl_pkg::S_IDLE: begin
				if (cmd_valid && dp_status.out_free && operation == bsl_pkg::OP_READ_ALL
						&& !dp_status.cnt_zero) begin
					state_d = bsl_pkg::S_READ;
				end
			end
			bsl_pkg::S_READ: begin
				if (dp_status.out_free && dp_status.rd_last) begin
					state_d = bsl_pkg::S_IDLE;
				end
			end
			default: state_d = bsl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready     = 1'b0;
		ctrl_cmd.exec = 1'b0;
		ctrl_cmd.step = 1'b0;
		case (state_q)
			bsl_pkg::S_IDLE: begin
				cmd_ready     = dp_status.out_free;
				ctrl_cmd.exec = cmd_valid && dp_status.out_free;
			end
			bsl_pkg::S_READ: begin
				ctrl_cmd.step = dp_status.out_free;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/bsl_dpath.sv
// Datapath: shifting cell bank, entry count, read index and result register.
// Depends on bsl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsl_dpath #(
	parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bsl_pkg::ctrl_cmd_t   ctrl_cmd,
	input  bsl_pkg::in_item_t    cmd,
	output bsl_pkg::dp_status_t  dp_status,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output bsl_pkg::out_item_t   rsp
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = (CW > bsl_pkg::CNT_W) ? CW : bsl_pkg::CNT_W;

	logic signed [bsl_pkg::DATA_W-1:0] cell_q [DEPTH];
	logic [CW-1:0]    count_q, count_d;
	logic [IW-1:0]    idx_q;
	logic             vld_q;
	bsl_pkg::out_item_t out_q, out_d;
	logic             load;

	logic             full, pos_ok, ins_ok, del_ok;
	logic [CMPW-1:0]  pos_x, cnt_x;

	assign full   = (count_q == CW'(DEPTH));
	assign pos_x  = CMPW'(cmd.position);
	assign cnt_x  = CMPW'(count_q);
	assign pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
	assign ins_ok = ctrl_cmd.exec && !full &&
		(cmd.operation == bsl_pkg::OP_INS_FRONT || cmd.operation == bsl_pkg::OP_INS_BACK);
	assign del_ok = ctrl_cmd.exec && cmd.operation == bsl_pkg::OP_DELETE && pos_ok;

	assign dp_status.out_free = !vld_q || rsp_ready;
	assign dp_status.cnt_zero = (count_q == '0);
	assign dp_status.rd_last  = ((CW'(idx_q) + CW'(1)) == count_q);

	// cell bank: a front insert or a read-out step shifts every cell, a delete the cells from its position on
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam int PRV = (g > 0) ? g - 1 : 0;
		localparam int NXT = (g < DEPTH - 1) ? g + 1 : g;
		always_ff @(posedge clk) begin
			if (ins_ok && cmd.operation == bsl_pkg::OP_INS_FRONT) begin
				cell_q[g] <= (g == 0) ? cmd.value : cell_q[PRV];
			end else if (ins_ok && count_q == CW'(g)) begin
				cell_q[g] <= cmd.value;
			end else if (del_ok && CMPW'(g + 1) >= pos_x) begin
				cell_q[g] <= cell_q[NXT];
			end else if (ctrl_cmd.step) begin
				cell_q[g] <= (count_q == CW'(g + 1)) ? cell_q[0] : cell_q[NXT];
			end
		end
	end

	always_comb begin
		logic [CMPW-1:0] cnt_n;
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CW'(1);
		end else if (del_ok) begin
			count_d = count_q - CW'(1);
		end
		cnt_n = CMPW'(count_d);
		load  = 1'b0;
		out_d.status      = bsl_pkg::ST_OK;
		out_d.entry_value = '0;
		out_d.entry_count = cnt_n[bsl_pkg::CNT_W-1:0];
		out_d.last        = 1'b1;
		if (ctrl_cmd.exec) begin
			case (cmd.operation)
				bsl_pkg::OP_INS_FRONT, bsl_pkg::OP_INS_BACK: begin
					load = 1'b1;
					if (full) begin
						out_d.status = bsl_pkg::ST_FULL;
					end
				end
				bsl_pkg::OP_DELETE: begin
					load = 1'b1;
					if (!pos_ok) begin
						out_d.status = bsl_pkg::ST_NOT_FOUND;
					end
				end
				bsl_pkg::OP_READ_ALL: begin
					load = dp_status.cnt_zero;
					out_d.status = bsl_pkg::ST_EMPTY;
				end
				default: load = 1'b0;
			endcase
		end else if (ctrl_cmd.step) begin
			load = 1'b1;
			out_d.entry_value = cell_q[0];
			out_d.last        = dp_status.rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			vld_q   <= 1'b0;
		end else begin
			count_q <= count_d;
			if (ctrl_cmd.exec) begin
				idx_q <= '0;
			end else if (ctrl_cmd.step) begin
				idx_q <= dp_status.rd_last ? '0 : idx_q + IW'(1);
			end
			if (load) begin
				vld_q <= 1'b1;
			end else if (rsp_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = vld_q;
	assign rsp       = out_q;

	`BSL_ASSERT(a_count_range, count_q <= CW'(DEPTH), "entry count above depth")
	`BSL_ASSERT(a_exec_step_excl, !(ctrl_cmd.exec && ctrl_cmd.step),
		"operation and read-out step together")
	`BSL_ASSERT_NEXT(a_step_loads, ctrl_cmd.step, vld_q, "read-out step gave no result")
	`BSL_ASSERT_NEXT(a_ins_count, ins_ok, count_q == $past(count_q) + CW'(1),
		"insert did not grow the list")

endmodule

`default_nettype wire

// File: test/bounded_sequence_list_checker.sv
// Checker for the bounded sequence list: watches the request and result channels,
// keeps its own copy of the list, and compares every result transfer with it.
// Depends on bsl_pkg.
`timescale 1ns / 100ps
`default_nettype none

module bounded_sequence_list_checker #(
	parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	input  wire                cmd_ready,
	input  bsl_pkg::in_item_t  cmd,
	input  wire                rsp_valid,
	input  wire                rsp_ready,
	input  bsl_pkg::out_item_t rsp,
	output int                 fail_count,
	output int                 pending
);
	import bsl_pkg::*;

	logic signed [DATA_W-1:0] list_cells [DEPTH];
	int                       list_len;
	out_item_t                expected_results [$];

	assign pending = expected_results.size();

	function automatic void push_result(status_t st, logic signed [DATA_W-1:0] v, logic fin);
		out_item_t res;
		res.status      = st;
		res.entry_value = v;
		res.entry_count = CNT_W'(list_len);
		res.last        = fin;
		expected_results.push_back(res);
	endfunction

	function automatic void apply_request(in_item_t req);
		int k;
		case (req.operation)
			OP_INS_FRONT, OP_INS_BACK: begin
				if (list_len >= DEPTH) begin
					push_result(ST_FULL, '0, 1'b1);
				end else begin
					if (req.operation == OP_INS_FRONT) begin
						for (k = list_len; k > 0; k--)
							list_cells[k] = list_cells[k - 1];
						list_cells[0] = req.value;
					end else begin
						list_cells[list_len] = req.value;
					end
					list_len++;
					push_result(ST_OK, '0, 1'b1);
				end
			end
			OP_DELETE: begin
				if (req.position < 1 || int'(req.position) > list_len) begin
					push_result(ST_NOT_FOUND, '0, 1'b1);
				end else begin
					for (k = req.position - 1; k + 1 < list_len; k++)
						list_cells[k] = list_cells[k + 1];
					list_len--;
					push_result(ST_OK, '0, 1'b1);
				end
			end
			default: begin
				if (list_len == 0) begin
					push_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (k = 0; k < list_len; k++)
						push_result(ST_OK, list_cells[k], k + 1 == list_len);
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_res;
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cmd_valid && cmd_ready)
				apply_request(cmd);
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					exp_res = expected_results.pop_front();
					if (rsp.status !== exp_res.status) begin
						$error("status: expected %0d, got %0d", exp_res.status, rsp.status);
						fail_count++;
					end
					if (rsp.entry_value !== exp_res.entry_value) begin
						$error("entry_value: expected %0d, got %0d",
							exp_res.entry_value, rsp.entry_value);
						fail_count++;
					end
					if (rsp.entry_count !== exp_res.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							exp_res.entry_count, rsp.entry_count);
						fail_count++;
					end
					if (rsp.last !== exp_res.last) begin
						$error("last: expected %0d, got %0d", exp_res.last, rsp.last);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: test/bounded_sequence_list_top_test.sv
// Testbench top for the bounded sequence list: clock, reset, request stimulus
// and result back-pressure; checking is done by bounded_sequence_list_checker.
// Depends on bsl_pkg, bounded_sequence_list_top and the checker.
`timescale 1ns / 100ps
`default_nettype none

module bounded_sequence_list_top_test;
	import bsl_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 2 * DEPTH + 20;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	in_item_t  cmd       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp;

	int  fail_count;
	int  pending;
	int  shadow_len  = 0;
	int  idle_cycles = 0;
	int  rsp_hold    = 0;
	bit  send_burst  = 1'b0;
	bit  recv_burst  = 1'b0;

	bounded_sequence_list_top #(.DEPTH(DEPTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	bounded_sequence_list_checker #(.DEPTH(DEPTH)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result back-pressure: after a transfer a fresh stall length is drawn, unless in a receive burst or on a 1-in-20 draw
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_hold  <= 0;
		end else if (rsp_valid && rsp_ready) begin
			if (recv_burst || $urandom_range(0, 19) == 0) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b0;
				rsp_hold  <= $urandom_range(0, 18);
			end
		end else if (!rsp_ready) begin
			if (rsp_hold == 0)
				rsp_ready <= 1'b1;
			else
				rsp_hold <= rsp_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("bounded_sequence_list_top regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic issue(op_t op, logic signed [DATA_W-1:0] v, logic [POS_W-1:0] pos);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.operation <= op;
		cmd.value     <= v;
		cmd.position  <= pos;
		cmd_valid     <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		case (op)
			OP_INS_FRONT, OP_INS_BACK:
				if (shadow_len < DEPTH) shadow_len++;
			OP_DELETE:
				if (pos >= 1 && int'(pos) <= shadow_len) shadow_len--;
			default: ;
		endcase
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if (shadow_len > 0 && $urandom_range(0, 9) < 8)
			return POS_W'($urandom_range(1, shadow_len));
		return POS_W'($urandom_range(0, 31));
	endfunction

	initial begin
		int  k;
		int  blk;
		int  roll;
		bit  grow;
		op_t op;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, single entry removed at the front, position zero
		issue(OP_READ_ALL, pick_value(), 5'd0);
		issue(OP_DELETE, pick_value(), 5'd1);
		issue(OP_INS_FRONT, 32'sh7fffffff, 5'd0);
		issue(OP_DELETE, '0, 5'd1);
		issue(OP_DELETE, '0, 5'd0);
		for (k = 0; k < DEPTH; k++) begin
			case (k)
				0:       issue(OP_INS_FRONT, 32'sh7fffffff, 5'd31);
				1:       issue(OP_INS_BACK, 32'sh80000000, 5'd0);
				2:       issue(OP_INS_FRONT, -32'sd1, 5'd0);
				3:       issue(OP_INS_BACK, '0, 5'd0);
				default: issue(k[0] ? OP_INS_BACK : OP_INS_FRONT, $urandom, 5'd0);
			endcase
		end
		issue(OP_INS_FRONT, 32'sh12345678, 5'd0);
		issue(OP_INS_BACK, 32'sh80000000, 5'd0);
		issue(OP_READ_ALL, '0, 5'd31);
		issue(OP_DELETE, '0, POS_W'(DEPTH));
		issue(OP_DELETE, '0, 5'd31);
		issue(OP_DELETE, '0, 5'd0);
		issue(OP_DELETE, '0, 5'd1);
		issue(OP_READ_ALL, '0, 5'd0);
		drain_results();

		// random part: blocks alternately fill and empty the list
		for (blk = 0; blk < 10; blk++) begin
			grow       = (blk % 2 == 0);
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			for (k = 0; k < 30; k++) begin
				roll = $urandom_range(0, 99);
				if (grow)
					op = roll < 40 ? OP_INS_FRONT : roll < 75 ? OP_INS_BACK :
						roll < 90 ? OP_DELETE : OP_READ_ALL;
				else
					op = roll < 15 ? OP_INS_FRONT : roll < 30 ? OP_INS_BACK :
						roll < 85 ? OP_DELETE : OP_READ_ALL;
				issue(op, pick_value(), op == OP_DELETE ? pick_position() :
					POS_W'($urandom_range(0, 31)));
			end
			if (blk % 3 == 1)
				drain_results();
		end
		send_burst = 1'b0;
		recv_burst = 1'b0;

		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("bounded_sequence_list_top regression: pass");
		else
			$display("bounded_sequence_list_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
